>>> hw/rtl/okl_pkg.sv
// okl_pkg: shared types, constants and helpers for the ordered key list engine.
// No dependencies.
package okl_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 37;
  localparam int OCNT_W   = 5;

  typedef enum logic [1:0] {
    OP_INS_TAIL = 2'd0,
    OP_INS_HEAD = 2'd1,
    OP_REM_HEAD = 2'd2,
    OP_REM_KEY  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    op_t              opcode;
    logic [KEY_W-1:0] key_value;
  } in_word_t;

  typedef struct packed {
    logic [OCNT_W-1:0] entry_count;
    status_t           status;
    logic              list_empty;
  } out_word_t;

  // position sum (below twice the capacity) folded back into the ring
  function automatic logic [IDX_W-1:0] idx_wrap(input logic [IDX_W:0] s);
    logic [IDX_W:0] r;
    r = (s >= (IDX_W+1)'(CAPACITY)) ? s - (IDX_W+1)'(CAPACITY) : s;
    return r[IDX_W-1:0];
  endfunction

endpackage

>>> hw/rtl/okl_ram.sv
// okl_ram: one write port, one read port, registered read data.
// No dependencies.
module okl_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 37,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/okl_seq.sv
// okl_seq: list sequencer; ring pointers, key search and gap closing over the key RAM.
// Depends on okl_pkg and okl_ram.
module okl_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  okl_pkg::in_word_t in_word,
  input  logic              slot_free,
  output logic              res_valid,
  output okl_pkg::out_word_t res_word
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SRD  = 6'b000010,
    S_SCMP = 6'b000100,
    S_MRD  = 6'b001000,
    S_MWR  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t                       state_r, state_nxt;
  logic [okl_pkg::IDX_W-1:0]    head_r, head_nxt;
  logic [okl_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [okl_pkg::IDX_W-1:0]    idx_r, idx_nxt;
  logic [okl_pkg::KEY_W-1:0]    key_r, key_nxt;
  okl_pkg::status_t             stat_r, stat_nxt;

  logic                         we;
  logic [okl_pkg::IDX_W-1:0]    waddr, raddr;
  logic [okl_pkg::KEY_W-1:0]    wdata, rdata;
  logic [okl_pkg::IDX_W-1:0]    pos_cur, pos_next;
  logic [okl_pkg::CNT_W:0]      idx_ext, cnt_ext;
  logic                         accept;

  okl_ram #(
    .DEPTH (okl_pkg::CAPACITY),
    .WIDTH (okl_pkg::KEY_W),
    .AW    (okl_pkg::IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign idx_ext  = (okl_pkg::CNT_W+1)'(idx_r);
  assign cnt_ext  = (okl_pkg::CNT_W+1)'(cnt_r);
  assign pos_cur  = okl_pkg::idx_wrap({1'b0, head_r} + {1'b0, idx_r});
  assign pos_next = okl_pkg::idx_wrap({1'b0, head_r} + {1'b0, idx_r}
                                      + (okl_pkg::IDX_W+1)'(1));

  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    key_nxt   = key_r;
    stat_nxt  = stat_r;
    we        = 1'b0;
    waddr     = pos_cur;
    wdata     = key_r;
    raddr     = pos_cur;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          key_nxt   = in_word.key_value;
          idx_nxt   = '0;
          stat_nxt  = okl_pkg::ST_OK;
          state_nxt = S_DONE;
          unique case (in_word.opcode) inside
            okl_pkg::OP_INS_TAIL, okl_pkg::OP_INS_HEAD: begin
              if (cnt_r >= okl_pkg::CNT_W'(okl_pkg::CAPACITY)) begin
                stat_nxt = okl_pkg::ST_FULL;
              end else begin
                we      = 1'b1;
                wdata   = in_word.key_value;
                cnt_nxt = cnt_r + okl_pkg::CNT_W'(1);
                if (in_word.opcode == okl_pkg::OP_INS_TAIL) begin
                  waddr = okl_pkg::idx_wrap({1'b0, head_r}
                                            + (okl_pkg::IDX_W+1)'(cnt_r));
                end else begin
                  head_nxt = (head_r == '0) ? okl_pkg::IDX_W'(okl_pkg::CAPACITY - 1)
                                            : head_r - okl_pkg::IDX_W'(1);
                  waddr    = head_nxt;
                end
              end
            end
            okl_pkg::OP_REM_HEAD: begin
              if (cnt_r == '0) begin
                stat_nxt = okl_pkg::ST_EMPTY;
              end else begin
                head_nxt = okl_pkg::idx_wrap({1'b0, head_r} + (okl_pkg::IDX_W+1)'(1));
                cnt_nxt  = cnt_r - okl_pkg::CNT_W'(1);
              end
            end
            default: begin
              if (cnt_r == '0) begin
                stat_nxt = okl_pkg::ST_EMPTY;
              end else begin
                state_nxt = S_SRD;
              end
            end
          endcase
        end
      end
      S_SRD: begin
        raddr     = pos_cur;
        state_nxt = S_SCMP;
      end
      S_SCMP: begin
        if (rdata == key_r) begin
          stat_nxt = okl_pkg::ST_OK;
          if (idx_ext + (okl_pkg::CNT_W+1)'(1) == cnt_ext) begin
            cnt_nxt   = cnt_r - okl_pkg::CNT_W'(1);
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_MRD;
          end
        end else if (idx_ext + (okl_pkg::CNT_W+1)'(1) == cnt_ext) begin
          stat_nxt  = okl_pkg::ST_NOT_FOUND;
          state_nxt = S_DONE;
        end else begin
          idx_nxt   = idx_r + okl_pkg::IDX_W'(1);
          state_nxt = S_SRD;
        end
      end
      S_MRD: begin
        raddr     = pos_next;
        state_nxt = S_MWR;
      end
      S_MWR: begin
        // pull the follower down over the gap
        we    = 1'b1;
        waddr = pos_cur;
        wdata = rdata;
        if (idx_ext + (okl_pkg::CNT_W+1)'(2) == cnt_ext) begin
          cnt_nxt   = cnt_r - okl_pkg::CNT_W'(1);
          state_nxt = S_DONE;
        end else begin
          idx_nxt   = idx_r + okl_pkg::IDX_W'(1);
          state_nxt = S_MRD;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign res_valid            = (state_r == S_DONE) && slot_free;
  assign res_word.entry_count = okl_pkg::OCNT_W'(cnt_r);
  assign res_word.status      = stat_r;
  assign res_word.list_empty  = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      cnt_r   <= cnt_nxt;
    end
    idx_r  <= idx_nxt;
    key_r  <= key_nxt;
    stat_r <= stat_nxt;
  end

endmodule

>>> hw/rtl/ordered_key_list_engine_unit.sv
// Ordered key list engine: keys kept as a ring in a 1-read/1-write RAM.
// Inserts, remove head and empty-list errors go from accept straight to the result;
// remove by key reads and compares entries from the head to a match or the end (S_SRD,
// S_SCMP), then pulls each later entry down over the gap (S_MRD, S_MWR), one RAM read port.
// One request in flight; the next is taken the cycle after its result is loaded.
// Reset: synchronous active-low rst_n empties the list; RAM contents are not cleared.
module ordered_key_list_engine_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  okl_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output okl_pkg::out_word_t out_word
);

  logic               out_valid_r;
  okl_pkg::out_word_t out_word_r;
  logic               slot_free;
  logic               res_valid;
  okl_pkg::out_word_t res_word;

  // output word can be (re)loaded when empty or being taken this cycle
  assign slot_free = !out_valid_r || !out_stall;

  okl_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .slot_free (slot_free),
    .res_valid (res_valid),
    .res_word  (res_word)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (res_valid) begin
      out_word_r <= res_word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

>>> hw/rtl/okl_checker.sv
// okl_checker: port-level assertions for the ordered key list engine, bound to the top.
// Depends on okl_pkg.
module okl_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input okl_pkg::in_word_t  in_word,
  input logic               out_valid,
  input logic               out_stall,
  input okl_pkg::out_word_t out_word
);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_word))
    else $error("stalled input word changed");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled output word changed");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.list_empty == (out_word.entry_count == '0)))
    else $error("empty flag disagrees with count");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.status == okl_pkg::ST_FULL
    |-> out_word.entry_count == okl_pkg::OCNT_W'(okl_pkg::CAPACITY))
    else $error("full status without full count");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while busy");

endmodule

bind ordered_key_list_engine_unit okl_checker u_okl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

>>> bench/testbench.sv
// Testbench for ordered_key_list_engine_unit: directed and random list requests,
// checked word by word against an in-bench model of the key list.
// Depends on okl_pkg and the engine RTL.
`timescale 1ns / 100ps

module testbench;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  okl_pkg::in_word_t  in_word = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  okl_pkg::out_word_t out_word;

  ordered_key_list_engine_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
  );

  always #10 clk = ~clk;

  // Model of the list: head at index 0.
  logic [okl_pkg::KEY_W-1:0] key_list[$];
  okl_pkg::out_word_t        pending_words[$];
  int                        error_count = 0;
  int                        sent_count = 0;
  int                        checked_count = 0;
  int                        status_seen[4] = '{0, 0, 0, 0};
  bit                        hold_off = 1'b0;  // long receiver stall request
  bit                        random_stall = 1'b0;

  function automatic okl_pkg::out_word_t list_apply(input okl_pkg::in_word_t w);
    okl_pkg::out_word_t r;
    okl_pkg::status_t   st;
    st = okl_pkg::ST_OK;
    case (w.opcode)
      okl_pkg::OP_INS_TAIL: if (key_list.size() >= okl_pkg::CAPACITY) st = okl_pkg::ST_FULL;
                            else key_list.push_back(w.key_value);
      okl_pkg::OP_INS_HEAD: if (key_list.size() >= okl_pkg::CAPACITY) st = okl_pkg::ST_FULL;
                            else key_list.push_front(w.key_value);
      okl_pkg::OP_REM_HEAD: if (key_list.size() == 0) st = okl_pkg::ST_EMPTY;
                            else void'(key_list.pop_front());
      default: begin
        if (key_list.size() == 0) st = okl_pkg::ST_EMPTY;
        else begin
          st = okl_pkg::ST_NOT_FOUND;
          // first match from the head only
          for (int i = 0; i < key_list.size(); i++) begin
            if (key_list[i] == w.key_value) begin
              key_list.delete(i);
              st = okl_pkg::ST_OK;
              break;
            end
          end
        end
      end
    endcase
    r.entry_count = okl_pkg::OCNT_W'(key_list.size());
    r.status      = st;
    r.list_empty  = (key_list.size() == 0);
    return r;
  endfunction

  // Mostly short gaps, sometimes long ones.
  function automatic int gap_len();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  // Valid drops between words; the engine stalls then anyway.
  task automatic send_word(input okl_pkg::op_t op, input logic [okl_pkg::KEY_W-1:0] key,
                           input bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    repeat (g + 1) @(negedge clk);
    in_word.opcode    <= op;
    in_word.key_value <= key;
    in_valid          <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_words.push_back(list_apply(in_word));
    sent_count++;
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic drain_wait();
    while (pending_words.size() != 0) @(negedge clk);
  endtask

  // Key choice: reuse a held key often so remove by key finds matches.
  function automatic logic [okl_pkg::KEY_W-1:0] pick_key();
    int s;
    s = $urandom_range(0, 9);
    if (s < 4 && key_list.size() != 0)
      return key_list[$urandom_range(0, key_list.size() - 1)];
    if (s < 6) return okl_pkg::KEY_W'($urandom_range(0, 7));
    if (s == 6) return {okl_pkg::KEY_W{1'b1}};
    return okl_pkg::KEY_W'({$urandom, $urandom});
  endfunction

  // Output checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_word);
        error_count++;
      end else begin
        okl_pkg::out_word_t e;
        e = pending_words.pop_front();
        checked_count++;
        status_seen[out_word.status]++;
        if (out_word.entry_count !== e.entry_count) begin
          $display("%0t: entry_count expected %0d actual %0d", $time,
                   e.entry_count, out_word.entry_count);
          error_count++;
        end
        if (out_word.status !== e.status) begin
          $display("%0t: status expected %s actual %s", $time,
                   e.status.name(), out_word.status.name());
          error_count++;
        end
        if (out_word.list_empty !== e.list_empty) begin
          $display("%0t: list_empty expected %b actual %b", $time,
                   e.list_empty, out_word.list_empty);
          error_count++;
        end
      end
    end
  end

  // Receiver stall driver; a hold-off request gives a long counted stall.
  always @(negedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else if (random_stall) out_stall <= ($urandom_range(0, 3) == 0);
    else out_stall <= 1'b0;
  end

  initial begin
    int cnt;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        cnt = 0;
        while (cnt < 200) begin
          @(negedge clk);
          cnt++;
        end
        hold_off = 1'b0;
      end
    end
  end

  // Directed: extremes, every op, empty, full, missing key, duplicates.
  task automatic test_directed();
    send_word(okl_pkg::OP_REM_HEAD, '0, 0);
    send_word(okl_pkg::OP_REM_KEY, '0, 0);
    send_word(okl_pkg::OP_INS_TAIL, {okl_pkg::KEY_W{1'b1}}, 0);
    send_word(okl_pkg::OP_INS_HEAD, '0, 0);
    send_word(okl_pkg::OP_INS_TAIL, 37'd99999999999, 0);
    send_word(okl_pkg::OP_INS_TAIL, 37'd99999999999, 0);
    send_word(okl_pkg::OP_REM_KEY, 37'd12345, 0);
    send_word(okl_pkg::OP_REM_KEY, 37'd99999999999, 0);
    send_word(okl_pkg::OP_REM_KEY, {okl_pkg::KEY_W{1'b1}}, 0);
    send_word(okl_pkg::OP_REM_HEAD, {okl_pkg::KEY_W{1'b1}}, 0);
    send_word(okl_pkg::OP_REM_KEY, 37'd99999999999, 0);
    for (int i = 0; i < okl_pkg::CAPACITY; i++)
      send_word(i[0] ? okl_pkg::OP_INS_HEAD : okl_pkg::OP_INS_TAIL,
                okl_pkg::KEY_W'(i), 0);
    send_word(okl_pkg::OP_INS_TAIL, 37'd5, 0);
    send_word(okl_pkg::OP_INS_HEAD, 37'd5, 0);
    send_word(okl_pkg::OP_REM_KEY, 37'd14, 0);  // match at the far end
    drain_wait();
  endtask

  // Random ops with random idling on both sides.
  task automatic test_random(input int n);
    int           r;
    okl_pkg::op_t op;
    random_stall = 1'b1;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      // bias toward growth when short, shrink when long
      if (key_list.size() < 4)
        op = (r < 60) ? okl_pkg::op_t'($urandom_range(0, 1))
                      : okl_pkg::op_t'($urandom_range(2, 3));
      else if (key_list.size() > 12)
        op = (r < 30) ? okl_pkg::op_t'($urandom_range(0, 1))
                      : okl_pkg::op_t'($urandom_range(2, 3));
      else op = okl_pkg::op_t'($urandom_range(0, 3));
      send_word(op, pick_key(), 1);
    end
    drain_wait();
    random_stall = 1'b0;
  endtask

  // Receiver holds off long while sender keeps offering words.
  task automatic test_backpressure();
    hold_off = 1'b1;
    for (int i = 0; i < 20; i++)
      send_word(okl_pkg::op_t'($urandom_range(0, 3)), pick_key(), 0);
    drain_wait();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random(400);
    test_backpressure();
    test_random(460);
    repeat (80) @(negedge clk);
    $display("Sent %0d words, checked %0d results", sent_count, checked_count);
    $display("Status counts ok/not found/empty/full: %0d/%0d/%0d/%0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (error_count == 0 && pending_words.size() == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("testbench failed");
    $finish;
  end

endmodule
